// File: rtl/vr_pkg.sv
// Shared types, constants and rounding and saturation helpers for the vector refraction core.
`default_nettype none
package vr_pkg;

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 29;
  localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;

  typedef struct packed {
    logic [2:0][31:0] m;
    logic [2:0]       sgn;
    logic [2:0][15:0] nv;
    logic [15:0]      eta;
    logic             zero;
  } side_a_t;

  typedef struct packed {
    logic [31:0]      len;
    logic [2:0]       sgn;
    logic [2:0][15:0] nv;
    logic [15:0]      eta;
    logic             zero;
  } side_d_t;

  typedef struct packed {
    logic [2:0][31:0] u;
    logic [2:0][15:0] nv;
    logic [15:0]      eta;
    logic [31:0]      d;
    logic             zero;
    logic             tir;
  } side_b_t;

  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input int unsigned s);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    logic [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'h7fff;
    end else if (v < -64'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/vector_refraction_core.sv
// Top level of the vector refraction core: normalize, Snell refraction, saturate.
//
//  channel | handshake        | beat
//  --------+------------------+-------------------------------------------------
//  input   | start / busy     | in_dir_x/y/z, in_norm_x/y/z, in_eta_ratio
//  result  | out_valid strobe | out_x, out_y, out_z, out_transmitted
//
// One beat is accepted every cycle; busy stays low.
// Each result passes through the two 32-stage square-root pipelines and the
// 29-stage divider pipeline after its beat is taken.
// Synchronous reset clears only the valid bits of the pipeline.
// The pipeline never stalls: the receiver takes every strobed result.
`default_nettype none
module vector_refraction_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_dir_x,
  input  wire logic [31:0] in_dir_y,
  input  wire logic [31:0] in_dir_z,
  input  wire logic [15:0] in_norm_x,
  input  wire logic [15:0] in_norm_y,
  input  wire logic [15:0] in_norm_z,
  input  wire logic [15:0] in_eta_ratio,
  output logic             out_valid,
  output logic [15:0]      out_x,
  output logic [15:0]      out_y,
  output logic [15:0]      out_z,
  output logic             out_transmitted
);

  localparam int ND = vr_pkg::DIV_STAGES;

  assign busy = 1'b0;

  logic [2:0][31:0] dir_a;
  logic [2:0][15:0] nrm_a;
  assign dir_a = {in_dir_z, in_dir_y, in_dir_x};
  assign nrm_a = {in_norm_z, in_norm_y, in_norm_x};

  // front: magnitude, max, shift amount, shift, squares, sum
  vr_pkg::side_a_t a1_r, a2_r, a3_r, a4_r, a5_r, a6_r, a1_nxt, a4_nxt;
  logic [31:0]      max2_r, max2_nxt;
  logic [4:0]       sh3_r, sh3_nxt;
  logic [2:0][63:0] sq5_r;
  logic [63:0]      lsq6_r;
  logic [6:1]       fv_r;

  always_comb begin
    a1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      a1_nxt.sgn[i] = dir_a[i][31];
      a1_nxt.m[i]   = dir_a[i][31] ? 32'(-dir_a[i]) : dir_a[i];
    end
    a1_nxt.nv   = nrm_a;
    a1_nxt.eta  = in_eta_ratio;
    a1_nxt.zero = (dir_a == '0);
  end

  always_comb begin
    max2_nxt = a1_r.m[0];
    if (a1_r.m[1] > max2_nxt) begin
      max2_nxt = a1_r.m[1];
    end
    if (a1_r.m[2] > max2_nxt) begin
      max2_nxt = a1_r.m[2];
    end
  end

  always_comb begin
    sh3_nxt = '0;
    for (int i = 0; i < 30; i++) begin
      if (max2_r[i]) begin
        sh3_nxt = 5'(30 - i);
      end
    end
    if (max2_r[31] || max2_r[30]) begin
      sh3_nxt = '0;
    end
  end

  always_comb begin
    a4_nxt = a3_r;
    for (int i = 0; i < 3; i++) begin
      a4_nxt.m[i] = a3_r.m[i] << sh3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      fv_r <= {fv_r[5:1], start & ~busy};
    end
    a1_r   <= a1_nxt;
    a2_r   <= a1_r;
    max2_r <= max2_nxt;
    a3_r   <= a2_r;
    sh3_r  <= sh3_nxt;
    a4_r   <= a4_nxt;
    a5_r   <= a4_r;
    for (int i = 0; i < 3; i++) begin
      sq5_r[i] <= a4_r.m[i] * a4_r.m[i];
    end
    a6_r   <= a5_r;
    lsq6_r <= sq5_r[0] + sq5_r[1] + sq5_r[2];
  end

  // length
  logic            sa_v;
  logic [31:0]     sa_root;
  vr_pkg::side_a_t sa_side;

  vr_sqrt #(.SIDE_W($bits(vr_pkg::side_a_t))) u_sqrt_len (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fv_r[6]),
    .in_x      (lsq6_r),
    .in_side   (a6_r),
    .out_valid (sa_v),
    .out_root  (sa_root),
    .out_side  (sa_side)
  );

  // divider: u = round(m * 2^28 / len)
  logic [2:0][31:0] rem_r  [0:ND];
  logic [2:0][28:0] w_r    [0:ND];
  vr_pkg::side_d_t  dside_r[0:ND];
  logic [ND:0]      dv_r;

  always_ff @(posedge clk) begin
    logic [59:0] num;
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= sa_v;
    end
    for (int i = 0; i < 3; i++) begin
      num = {sa_side.m[i], 28'd0} + 60'(sa_root[31:1]);
      rem_r[0][i] <= {1'b0, num[59:29]};
      w_r[0][i]   <= num[28:0];
    end
    dside_r[0].len  <= sa_root;
    dside_r[0].sgn  <= sa_side.sgn;
    dside_r[0].nv   <= sa_side.nv;
    dside_r[0].eta  <= sa_side.eta;
    dside_r[0].zero <= sa_side.zero;
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [2:0][31:0] rem_nxt;
    logic [2:0][28:0] w_nxt;
    always_comb begin
      logic [32:0] tmp;
      logic        ge;
      for (int i = 0; i < 3; i++) begin
        tmp        = {rem_r[k][i], w_r[k][i][28]};
        ge         = tmp >= {1'b0, dside_r[k].len};
        rem_nxt[i] = ge ? 32'(tmp - {1'b0, dside_r[k].len}) : tmp[31:0];
        w_nxt[i]   = {w_r[k][i][27:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else begin
        dv_r[k+1] <= dv_r[k];
      end
      rem_r[k+1]   <= rem_nxt;
      w_r[k+1]     <= w_nxt;
      dside_r[k+1] <= dside_r[k];
    end
  end

  // middle: d, d^2, disc
  vr_pkg::side_b_t  b8_r, b9_r, b10_r, b11_r, b12_r, b13_r, b14_r, b15_r, b16_r;
  vr_pkg::side_b_t  b8_nxt, b10_nxt, b16_nxt;
  logic [2:0][63:0] p9_r;
  logic signed [63:0] dd11_r, om12_r, p13_r, r14_r, p15_r;
  logic [63:0]      x16_r, x16_nxt;
  logic [16:8]      mv_r;

  always_comb begin
    b8_nxt      = '0;
    for (int i = 0; i < 3; i++) begin
      b8_nxt.u[i] = dside_r[ND].sgn[i] ? 32'(-{3'd0, w_r[ND][i]}) : {3'd0, w_r[ND][i]};
    end
    b8_nxt.nv   = dside_r[ND].nv;
    b8_nxt.eta  = dside_r[ND].eta;
    b8_nxt.zero = dside_r[ND].zero;
  end

  always_comb begin
    logic signed [63:0] sum;
    sum     = $signed(p9_r[0]) + $signed(p9_r[1]) + $signed(p9_r[2]);
    b10_nxt   = b9_r;
    b10_nxt.d = 32'(vr_pkg::rnd_sh(sum, 14));
  end

  always_comb begin
    logic signed [63:0] e, disc;
    e           = vr_pkg::rnd_sh(p15_r, 14);
    disc        = vr_pkg::ONE_Q28 - e;
    b16_nxt     = b15_r;
    b16_nxt.tir = (disc <= 64'sd0);
    x16_nxt     = {disc[35:0], 28'd0};
  end

  always_ff @(posedge clk) begin
    logic signed [47:0] pu;
    logic signed [16:0] eta_s;
    if (!rst_n) begin
      mv_r <= '0;
    end else begin
      mv_r <= {mv_r[15:8], dv_r[ND]};
    end
    b8_r <= b8_nxt;
    b9_r <= b8_r;
    for (int i = 0; i < 3; i++) begin
      pu       = $signed(b8_r.u[i]) * $signed(b8_r.nv[i]);
      p9_r[i] <= 64'(pu);
    end
    b10_r  <= b10_nxt;
    b11_r  <= b10_r;
    dd11_r <= 64'($signed(b10_r.d)) * 64'($signed(b10_r.d));
    b12_r  <= b11_r;
    om12_r <= vr_pkg::ONE_Q28 - vr_pkg::rnd_sh(dd11_r, 28);
    b13_r  <= b12_r;
    eta_s   = $signed({1'b0, b12_r.eta});
    p13_r  <= 64'(eta_s * $signed(om12_r[39:0]));
    b14_r  <= b13_r;
    r14_r  <= vr_pkg::rnd_sh(p13_r, 14);
    b15_r  <= b14_r;
    p15_r  <= 64'($signed({1'b0, b14_r.eta}) * $signed(r14_r[43:0]));
    b16_r  <= b16_nxt;
    x16_r  <= x16_nxt;
  end

  // sqrt of disc
  logic            sb_v;
  logic [31:0]     sb_root;
  vr_pkg::side_b_t sb_side;

  vr_sqrt #(.SIDE_W($bits(vr_pkg::side_b_t))) u_sqrt_disc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mv_r[16]),
    .in_x      (x16_r),
    .in_side   (b16_r),
    .out_valid (sb_v),
    .out_root  (sb_root),
    .out_side  (sb_side)
  );

  // back: refracted vector
  vr_pkg::side_b_t  b17_r, b18_r, b19_r;
  logic [31:0]      s17_r;
  logic [2:0][63:0] nd17_r, a18_r, ns18_r, ns19_r, ae19_r;
  logic [19:17]     bv_r;

  always_ff @(posedge clk) begin
    logic signed [47:0] pnd;
    logic signed [48:0] pns;
    logic signed [56:0] pae;
    logic signed [63:0] t;
    if (!rst_n) begin
      bv_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      bv_r      <= {bv_r[18:17], sb_v};
      out_valid <= bv_r[19];
    end
    b17_r <= sb_side;
    s17_r <= sb_root;
    b18_r <= b17_r;
    b19_r <= b18_r;
    for (int i = 0; i < 3; i++) begin
      pnd        = $signed(sb_side.nv[i]) * $signed(sb_side.d);
      nd17_r[i] <= 64'(pnd);
      a18_r[i]  <= 64'($signed(b17_r.u[i])) - vr_pkg::rnd_sh($signed(nd17_r[i]), 14);
      pns        = $signed(b17_r.nv[i]) * $signed({1'b0, s17_r});
      ns18_r[i] <= 64'(pns);
      pae        = $signed(a18_r[i][39:0]) * $signed({1'b0, b18_r.eta});
      ae19_r[i] <= 64'(pae);
      ns19_r[i] <= ns18_r[i];
    end
    t     = vr_pkg::rnd_sh($signed(ae19_r[0]) - $signed(ns19_r[0]), 28);
    out_x <= (b19_r.zero || b19_r.tir) ? 16'd0 : vr_pkg::sat16(t);
    t     = vr_pkg::rnd_sh($signed(ae19_r[1]) - $signed(ns19_r[1]), 28);
    out_y <= (b19_r.zero || b19_r.tir) ? 16'd0 : vr_pkg::sat16(t);
    t     = vr_pkg::rnd_sh($signed(ae19_r[2]) - $signed(ns19_r[2]), 28);
    out_z <= (b19_r.zero || b19_r.tir) ? 16'd0 : vr_pkg::sat16(t);
    out_transmitted <= ~(b19_r.zero | b19_r.tir);
  end

endmodule
`default_nettype wire

// File: rtl/vr_sqrt.sv
// Pipelined integer square root of a 64-bit word, one result bit per stage.
`default_nettype none
module vr_sqrt #(
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [63:0]       in_x,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [31:0]            out_root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int N = vr_pkg::SQRT_STAGES;

  logic [63:0]       x_r    [0:N-1];
  logic [63:0]       res_r  [0:N-1];
  logic [SIDE_W-1:0] side_r [0:N-1];
  logic [N-1:0]      v_r;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [63:0]       x_in, res_in, bit_v, sum_v, x_nxt, res_nxt;
    logic [SIDE_W-1:0] side_in;
    logic              v_in;
    if (k == 0) begin : g_first
      assign x_in    = in_x;
      assign res_in  = 64'd0;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign x_in    = x_r[k-1];
      assign res_in  = res_r[k-1];
      assign side_in = side_r[k-1];
      assign v_in    = v_r[k-1];
    end
    always_comb begin
      bit_v = 64'd1 << (62 - 2 * k);
      sum_v = res_in + bit_v;
      if (x_in >= sum_v) begin
        x_nxt   = x_in - sum_v;
        res_nxt = (res_in >> 1) + bit_v;
      end else begin
        x_nxt   = x_in;
        res_nxt = res_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
      x_r[k]    <= x_nxt;
      res_r[k]  <= res_nxt;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = res_r[N-1][31:0];
  assign out_side  = side_r[N-1];

endmodule
`default_nettype wire
